/* rtl/qmn_pkg.sv */
package qmn_pkg;

   // component format
   localparam int CompWidth = 16;
   localparam int FracBits  = 14;

   // scaled magnitude format: largest component magnitude normalized into [2^29, 2^30)
   localparam int ScaleBits = 30;
   localparam int SumBits   = 2 * ScaleBits + 2;
   localparam int RootBits  = ScaleBits + 1;
   localparam int QuoBits   = FracBits + 1;

   // largest output magnitude: min(2^FracBits, 2^(CompWidth-1)-1)
   localparam int OneVal  = 1 << FracBits;
   localparam int MaxPos  = (1 << (CompWidth - 1)) - 1;
   localparam int LimitVal = (OneVal < MaxPos) ? OneVal : MaxPos;

   typedef struct packed {
      logic signed [CompWidth-1:0] a_w;
      logic signed [CompWidth-1:0] a_x;
      logic signed [CompWidth-1:0] a_y;
      logic signed [CompWidth-1:0] a_z;
      logic signed [CompWidth-1:0] b_w;
      logic signed [CompWidth-1:0] b_x;
      logic signed [CompWidth-1:0] b_y;
      logic signed [CompWidth-1:0] b_z;
   } req_type;

   typedef struct packed {
      logic signed [CompWidth-1:0] p_w;
      logic signed [CompWidth-1:0] p_x;
      logic signed [CompWidth-1:0] p_y;
      logic signed [CompWidth-1:0] p_z;
      logic                        zero_magnitude;
   } rsp_type;

   // per-transaction data that rides alongside the root and divide stages
   typedef struct packed {
      logic                             zero;
      logic [3:0]                       neg;
      logic [3:0][ScaleBits-1:0]        mag_abs;
   } side_type;

endpackage

/* rtl/qmn_sqrt.sv */
module qmn_sqrt
   import qmn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                sq_valid,
   input  logic [SumBits-1:0]  sq_sum,
   input  side_type            sq_side,
   output logic                rt_valid,
   output logic [RootBits-1:0] rt_root,
   output side_type            rt_side
);

   // one result bit per stage, most significant first
   logic                stg_valid [RootBits+1];
   logic [SumBits-1:0]  stg_rem   [RootBits+1];
   logic [RootBits-1:0] stg_root  [RootBits+1];
   side_type            stg_side  [RootBits+1];

   assign stg_valid[0] = sq_valid;
   assign stg_rem[0]   = sq_sum;
   assign stg_root[0]  = '0;
   assign stg_side[0]  = sq_side;

   for (genvar g = 0; g < RootBits; g++) begin : g_stage
      localparam int B = RootBits - 1 - g;

      logic                valid_ff;
      logic [SumBits-1:0]  rem_ff, rem_in;
      logic [RootBits-1:0] root_ff, root_in;
      side_type            side_ff;
      logic [SumBits:0]    trial;

      // try the next root bit against the remainder
      always_comb begin
         trial   = ((SumBits+1)'(stg_root[g]) << (B + 1)) | ((SumBits+1)'(1) << (2 * B));
         rem_in  = stg_rem[g];
         root_in = stg_root[g];
         if ({1'b0, stg_rem[g]} >= trial) begin
            rem_in  = stg_rem[g] - SumBits'(trial);
            root_in = stg_root[g] | (RootBits'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= stg_valid[g];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= stg_side[g];
      end

      assign stg_valid[g+1] = valid_ff;
      assign stg_rem[g+1]   = rem_ff;
      assign stg_root[g+1]  = root_ff;
      assign stg_side[g+1]  = side_ff;
   end

   assign rt_valid = stg_valid[RootBits];
   assign rt_root  = stg_root[RootBits];
   assign rt_side  = stg_side[RootBits];

endmodule

/* rtl/qmn_div.sv */
module qmn_div
   import qmn_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                dv_valid,
   input  logic [RootBits-1:0] dv_root,
   input  side_type            dv_side,
   output logic                rsp_valid,
   output rsp_type             rsp_data
);

   localparam int NumBits = ScaleBits + QuoBits + 2;
   localparam int DenBits = RootBits + 1;

   typedef logic [3:0][NumBits-1:0] rem_type;
   typedef logic [3:0][QuoBits-1:0] quo_type;

   logic                stg_valid [QuoBits+1];
   rem_type             stg_rem   [QuoBits+1];
   quo_type             stg_quo   [QuoBits+1];
   logic [DenBits-1:0]  stg_den   [QuoBits+1];
   logic                stg_zero  [QuoBits+1];
   logic [3:0]          stg_neg   [QuoBits+1];

   // numerator 2*|c|*2^frac + mag over denominator 2*mag rounds half away
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         stg_rem[0][n] = (NumBits'(dv_side.mag_abs[n]) << (FracBits + 1))
                         + NumBits'(dv_root);
      end
   end
   assign stg_valid[0] = dv_valid;
   assign stg_quo[0]   = '0;
   assign stg_den[0]   = {dv_root, 1'b0};
   assign stg_zero[0]  = dv_side.zero;
   assign stg_neg[0]   = dv_side.neg;

   for (genvar g = 0; g < QuoBits; g++) begin : g_stage
      localparam int B = QuoBits - 1 - g;

      logic               valid_ff;
      rem_type            rem_ff, rem_in;
      quo_type            quo_ff, quo_in;
      logic [DenBits-1:0] den_ff;
      logic               zero_ff;
      logic [3:0]         neg_ff;
      logic [NumBits-1:0] trial;

      // subtract the shifted divisor where it fits, lane by lane
      always_comb begin
         trial  = NumBits'(stg_den[g]) << B;
         rem_in = stg_rem[g];
         quo_in = stg_quo[g];
         for (int n = 0; n < 4; n++) begin
            if (stg_rem[g][n] >= trial) begin
               rem_in[n] = stg_rem[g][n] - trial;
               quo_in[n] = stg_quo[g][n] | (QuoBits'(1) << B);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= stg_valid[g];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= stg_den[g];
         zero_ff <= stg_zero[g];
         neg_ff  <= stg_neg[g];
      end

      assign stg_valid[g+1] = valid_ff;
      assign stg_rem[g+1]   = rem_ff;
      assign stg_quo[g+1]   = quo_ff;
      assign stg_den[g+1]   = den_ff;
      assign stg_zero[g+1]  = zero_ff;
      assign stg_neg[g+1]   = neg_ff;
   end

   // saturate, restore sign, force zeros for a zero product
   logic                              out_valid_ff;
   rsp_type                           out_data_ff, out_data_in;
   logic [3:0][CompWidth-1:0]         comp;

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         logic [QuoBits-1:0] q;
         logic [CompWidth-1:0] mag;
         q = stg_quo[QuoBits][n];
         if (q > QuoBits'(LimitVal)) begin
            q = QuoBits'(LimitVal);
         end
         mag = CompWidth'(q);
         comp[n] = stg_neg[QuoBits][n] ? (~mag + CompWidth'(1)) : mag;
         if (stg_zero[QuoBits]) begin
            comp[n] = '0;
         end
      end
      out_data_in.p_w            = comp[0];
      out_data_in.p_x            = comp[1];
      out_data_in.p_y            = comp[2];
      out_data_in.p_z            = comp[3];
      out_data_in.zero_magnitude = stg_zero[QuoBits];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= stg_valid[QuoBits];
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* rtl/quaternion_multiply_normalise.sv */
// Normalized Hamilton product of two quaternions in signed Q2.14.
// Input channel: drive req_data and raise start; the transaction is taken at
// any rising edge with start high and busy low. busy never rises, so a new
// transaction may enter on every cycle.
// Result channel: rsp_valid is high for exactly one cycle with rsp_data; the
// receiver cannot stall, so each result must be taken in that cycle.
// Throughput: one transaction per cycle. The depth is set by the 31-stage
// square root (one root bit per stage) and the 15-stage divider (one quotient
// bit per stage, four lanes) with its output register, behind six stages of
// multiply, sum, block scaling and squaring.
// Results leave in the order transactions were accepted.
// Reset: synchronous, active high; clears all stage valid bits, so no result
// appears for transactions in flight at reset. No clearing pass is needed.
// A product of all zeros gives zero components with zero_magnitude set.
module quaternion_multiply_normalise
   import qmn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CBits = 2 * CompWidth + 2;
   localparam int DBits = ScaleBits + 1;
   localparam logic signed [CBits-1:0] TopVal = CBits'((1 << ScaleBits) - 1);

   logic accept;
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // stage 1: sixteen products
   logic                          v1_ff;
   logic signed [2*CompWidth-1:0] pr_ff [16];
   logic signed [2*CompWidth-1:0] pr_in [16];

   always_comb begin
      pr_in[0]  = req_data.a_w * req_data.b_w;
      pr_in[1]  = req_data.a_x * req_data.b_x;
      pr_in[2]  = req_data.a_y * req_data.b_y;
      pr_in[3]  = req_data.a_z * req_data.b_z;
      pr_in[4]  = req_data.a_x * req_data.b_w;
      pr_in[5]  = req_data.b_x * req_data.a_w;
      pr_in[6]  = req_data.a_y * req_data.b_z;
      pr_in[7]  = req_data.a_z * req_data.b_y;
      pr_in[8]  = req_data.a_y * req_data.b_w;
      pr_in[9]  = req_data.b_y * req_data.a_w;
      pr_in[10] = req_data.a_z * req_data.b_x;
      pr_in[11] = req_data.a_x * req_data.b_z;
      pr_in[12] = req_data.a_z * req_data.b_w;
      pr_in[13] = req_data.b_z * req_data.a_w;
      pr_in[14] = req_data.a_x * req_data.b_y;
      pr_in[15] = req_data.a_y * req_data.b_x;
   end

   // stage 2: product components and zero detect
   logic                    v2_ff;
   logic signed [CBits-1:0] c_ff [4];
   logic signed [CBits-1:0] c_in [4];
   logic                    z2_ff, z2_in;

   always_comb begin
      c_in[0] = CBits'(pr_ff[0]) - CBits'(pr_ff[1]) - CBits'(pr_ff[2]) - CBits'(pr_ff[3]);
      c_in[1] = CBits'(pr_ff[4]) + CBits'(pr_ff[5]) + CBits'(pr_ff[6]) - CBits'(pr_ff[7]);
      c_in[2] = CBits'(pr_ff[8]) + CBits'(pr_ff[9]) + CBits'(pr_ff[10]) - CBits'(pr_ff[11]);
      c_in[3] = CBits'(pr_ff[12]) + CBits'(pr_ff[13]) + CBits'(pr_ff[14]) - CBits'(pr_ff[15]);
      z2_in   = (c_in[0] == '0) && (c_in[1] == '0) && (c_in[2] == '0) && (c_in[3] == '0);
   end

   // stage 3: shift down (floor) until every magnitude is below 2^30
   logic                    v3_ff;
   logic                    z3_ff;
   logic signed [DBits-1:0] dn_ff [4];
   logic signed [DBits-1:0] dn_in [4];
   logic [4:0]              fits;
   logic [2:0]              down_sel;

   always_comb begin
      for (int k = 0; k < 5; k++) begin
         fits[k] = 1'b1;
         for (int n = 0; n < 4; n++) begin
            if (((c_ff[n] >>> k) > TopVal) || ((c_ff[n] >>> k) < -TopVal)) begin
               fits[k] = 1'b0;
            end
         end
      end
      down_sel = 3'd4;
      for (int k = 4; k >= 0; k--) begin
         if (fits[k]) begin
            down_sel = 3'(k);
         end
      end
      for (int n = 0; n < 4; n++) begin
         dn_in[n] = DBits'(c_ff[n] >>> down_sel);
      end
   end

   // stage 4: take magnitudes and shift up until the largest reaches 2^29
   logic                       v4_ff;
   logic                       z4_ff;
   logic [3:0]                 neg4_ff, neg4_in;
   logic [3:0][ScaleBits-1:0]  sc4_ff, sc4_in;
   logic [3:0][ScaleBits-1:0]  ab;
   logic [ScaleBits-1:0]       all_or;
   logic [4:0]                 top_pos;
   logic [4:0]                 up_sh;

   always_comb begin
      all_or = '0;
      for (int n = 0; n < 4; n++) begin
         neg4_in[n] = dn_ff[n][DBits-1];
         ab[n]      = ScaleBits'(neg4_in[n] ? -dn_ff[n] : dn_ff[n]);
         all_or     = all_or | ab[n];
      end
      top_pos = 5'(ScaleBits - 1);
      for (int b = 0; b < ScaleBits; b++) begin
         if (all_or[b]) begin
            top_pos = 5'(b);
         end
      end
      up_sh = 5'(ScaleBits - 1) - top_pos;
      for (int n = 0; n < 4; n++) begin
         sc4_in[n] = ab[n] << up_sh;
      end
   end

   // stage 5: squares
   logic                        v5_ff;
   side_type                    sd5_ff;
   logic [3:0][2*ScaleBits-1:0] sq_ff, sq_in;

   always_comb begin
      for (int n = 0; n < 4; n++) begin
         sq_in[n] = sc4_ff[n] * sc4_ff[n];
      end
   end

   // stage 6: sum of squares
   logic               v6_ff;
   side_type           sd6_ff;
   logic [SumBits-1:0] sum_ff, sum_in;

   always_comb begin
      sum_in = SumBits'(sq_ff[0]) + SumBits'(sq_ff[1])
             + SumBits'(sq_ff[2]) + SumBits'(sq_ff[3]);
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      pr_ff   <= pr_in;
      c_ff    <= c_in;
      z2_ff   <= z2_in;
      dn_ff   <= dn_in;
      z3_ff   <= z2_ff;
      sc4_ff  <= sc4_in;
      neg4_ff <= neg4_in;
      z4_ff   <= z3_ff;
      sq_ff   <= sq_in;
      sd5_ff.zero    <= z4_ff;
      sd5_ff.neg     <= neg4_ff;
      sd5_ff.mag_abs <= sc4_ff;
      sum_ff  <= sum_in;
      sd6_ff  <= sd5_ff;
   end

   logic                rt_valid;
   logic [RootBits-1:0] rt_root;
   side_type            rt_side;

   qmn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sq_valid (v6_ff),
      .sq_sum   (sum_ff),
      .sq_side  (sd6_ff),
      .rt_valid (rt_valid),
      .rt_root  (rt_root),
      .rt_side  (rt_side)
   );

   qmn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .dv_valid  (rt_valid),
      .dv_root   (rt_root),
      .dv_side   (rt_side),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import qmn_pkg::*;

   localparam int LATENCY   = 53;
   localparam int WDOG_MAX  = 2000;
   localparam int N_RANDOM  = 1730;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type pending_q[$];
   rsp_type product_q[$];
   int      idle_pct;
   bit      hold_until_drained;
   int      n_sent;
   int      n_got;
   int      n_zero;
   int      n_bad;
   int      stale_cnt;
   bit      done_feeding;

   quaternion_multiply_normalise dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Integer square root, floor.
   function automatic logic [63:0] isqrt(input logic [63:0] s);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s   = s - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint max_mag(input longint c[4]);
      longint m;
      m = 0;
      for (int i = 0; i < 4; i++) begin
         if ((c[i] < 0 ? -c[i] : c[i]) > m) m = (c[i] < 0 ? -c[i] : c[i]);
      end
      return m;
   endfunction

   // Compute the normalized Hamilton product of one request.
   function automatic rsp_type unit_product(input req_type r);
      longint aw, ax, ay, az, bw, bx, by, bz;
      longint c[4];
      longint m;
      logic [63:0] s, mag, a, q;
      rsp_type o;
      aw = r.a_w; ax = r.a_x; ay = r.a_y; az = r.a_z;
      bw = r.b_w; bx = r.b_x; by = r.b_y; bz = r.b_z;
      c[0] = aw*bw - ax*bx - ay*by - az*bz;
      c[1] = ax*bw + bx*aw + ay*bz - az*by;
      c[2] = ay*bw + by*aw + az*bx - ax*bz;
      c[3] = az*bw + bz*aw + ax*by - ay*bx;
      o = '0;
      m = max_mag(c);
      if (m == 0) begin
         o.zero_magnitude = 1'b1;
         return o;
      end
      // scale the block so the largest component lies in [2^29, 2^30)
      while (m >= (64'sd1 <<< 30)) begin
         for (int i = 0; i < 4; i++) c[i] = c[i] >>> 1;
         m = max_mag(c);
      end
      while (m < (64'sd1 <<< 29)) begin
         for (int i = 0; i < 4; i++) c[i] = c[i] * 2;
         m = max_mag(c);
      end
      s = 0;
      for (int i = 0; i < 4; i++) begin
         a = c[i] < 0 ? -c[i] : c[i];
         s = s + a * a;
      end
      mag = isqrt(s);
      for (int i = 0; i < 4; i++) begin
         a = c[i] < 0 ? -c[i] : c[i];
         q = ((a << (FracBits + 1)) + mag) / (2 * mag);
         if (q > LimitVal) q = LimitVal;
         if (c[i] < 0) q = -q;
         case (i)
            0: o.p_w = q[CompWidth-1:0];
            1: o.p_x = q[CompWidth-1:0];
            2: o.p_y = q[CompWidth-1:0];
            default: o.p_z = q[CompWidth-1:0];
         endcase
      end
      return o;
   endfunction

   function automatic logic [CompWidth-1:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff;
         1: return 16'(int'($urandom_range(0, 64)) - 32);
         2: return $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
         default: return CompWidth'($urandom);
      endcase
   endfunction

   function automatic req_type rand_req();
      req_type r;
      r = {rand_comp(), rand_comp(), rand_comp(), rand_comp(),
           rand_comp(), rand_comp(), rand_comp(), rand_comp()};
      // sometimes zero a_w alone, or one side entirely to hit the zero product
      if ($urandom_range(0, 40) == 0) r.a_w = 0;
      if ($urandom_range(0, 60) == 0) {r.a_w, r.a_x, r.a_y, r.a_z} = '0;
      if ($urandom_range(0, 60) == 0) {r.b_w, r.b_x, r.b_y, r.b_z} = '0;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Directed items, then random phases with different sender idling.
   initial begin
      req_type r;
      idle_pct           = 0;
      hold_until_drained = 1'b0;
      done_feeding       = 1'b0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      pending_q.push_back('0);
      pending_q.push_back({16'h4000, 48'h0, 16'h4000, 48'h0});
      pending_q.push_back({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                           16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
      pending_q.push_back({8{16'h8000}});
      pending_q.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                           16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
      pending_q.push_back({16'h0001, 48'h0, 16'h0001, 48'h0});
      pending_q.push_back({16'h0001, 48'h0, 16'hffff, 48'h0});
      pending_q.push_back({16'h0, 16'h4000, 32'h0, 16'h0, 16'h4000, 32'h0});
      pending_q.push_back({32'h0, 16'h4000, 16'h0, 48'h0, 16'h4000});
      pending_q.push_back({16'h2d41, 16'h2d41, 32'h0, 16'h2d41, 16'hd2bf, 32'h0});
      pending_q.push_back({16'h0001, 16'h0001, 16'h0001, 16'h0001,
                           16'hffff, 16'h0001, 16'hffff, 16'h0001});
      pending_q.push_back({16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0});
      pending_q.push_back({64'h0, 16'h1234, 16'hedcb, 16'h0042, 16'hffbe});
      for (int p = 0; p < 4; p++) begin
         idle_pct = (p == 1) ? 78 : (p == 3) ? 14 : 0;
         for (int i = 0; i < N_RANDOM / 4; i++) pending_q.push_back(rand_req());
         wait (pending_q.size() == 0);
         if (p == 1) begin
            // pause until the pipeline drains, after the last transaction is taken
            hold_until_drained = 1'b1;
            @(posedge clock);
            wait (product_q.size() == 0);
            hold_until_drained = 1'b0;
         end
      end
      done_feeding = 1'b1;
   end

   // Clear the request outputs while reset is high.
   always @(negedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else if (start && !busy) begin
         // the transaction was taken at the last rising edge
      end else begin
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         product_q.push_back(unit_product(req_data));
         n_sent <= n_sent + 1;
      end
   end

   // Choose the next request at the falling edge.
   always @(negedge clock) begin
      if (!reset && !(start && busy)) begin
         if (pending_q.size() != 0 && !hold_until_drained &&
             $urandom_range(1, 100) > idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_q.pop_front();
         end else begin
            start    <= 1'b0;
         end
      end
   end

   // Check each result against the oldest expected product.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         n_got <= n_got + 1;
         if (rsp_data.zero_magnitude) n_zero <= n_zero + 1;
         if (product_q.size() == 0) begin
            n_bad = n_bad + 1;
            if (n_bad <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            want = product_q.pop_front();
            if (want !== rsp_data) begin
               n_bad = n_bad + 1;
               if (n_bad <= 10)
                  $display("mismatch: expected w=%0d x=%0d y=%0d z=%0d zm=%b, got w=%0d x=%0d y=%0d z=%0d zm=%b",
                     want.p_w, want.p_x, want.p_y, want.p_z, want.zero_magnitude,
                     rsp_data.p_w, rsp_data.p_x, rsp_data.p_y, rsp_data.p_z,
                     rsp_data.zero_magnitude);
            end
         end
      end
   end

   // Watchdog on cycles with neither an accepted transaction nor a result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stale_cnt <= 0;
      end else begin
         stale_cnt <= stale_cnt + 1;
         if (stale_cnt >= WDOG_MAX) begin
            $display("watchdog expired");
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   initial begin
      n_sent = 0;
      n_got  = 0;
      n_zero = 0;
      n_bad  = 0;
      stale_cnt = 0;
      start    = 1'b0;
      req_data = '0;
      wait (done_feeding);
      wait (product_q.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (product_q.size() != 0) n_bad = n_bad + 1;
      $display("%0d quaternion pairs sent, %0d products checked, %0d zero-magnitude",
               n_sent, n_got, n_zero);
      $display("phases: back-to-back, sparse sender with drain pause, back-to-back, light gaps");
      if (n_bad == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/qmn_pkg.sv
rtl/qmn_sqrt.sv
rtl/qmn_div.sv
rtl/quaternion_multiply_normalise.sv
tb/testbench.sv
